// ===== hdl/crf_pkg.sv =====
// crf_pkg: types and codes shared by the register file and flag alu
// no dependencies
`default_nettype none
package crf_pkg;

  typedef enum logic [4:0] {
    CMD_RD8    = 5'd0,
    CMD_WR8    = 5'd1,
    CMD_RD16   = 5'd2,
    CMD_WR16   = 5'd3,
    CMD_INC8   = 5'd4,
    CMD_DEC8   = 5'd5,
    CMD_INC16  = 5'd6,
    CMD_DEC16  = 5'd7,
    CMD_ADD8   = 5'd8,
    CMD_ADD16  = 5'd9,
    CMD_SBCHL  = 5'd10,
    CMD_RLC    = 5'd11,
    CMD_RRC    = 5'd12,
    CMD_RL     = 5'd13,
    CMD_RR     = 5'd14,
    CMD_DAA    = 5'd15,
    CMD_NEG    = 5'd16,
    CMD_EXAF   = 5'd17,
    CMD_EXX    = 5'd18,
    CMD_JR     = 5'd19,
    CMD_COND   = 5'd20,
    CMD_RESET  = 5'd21,
    CMD_IFF1   = 5'd22,
    CMD_IFF2   = 5'd23,
    CMD_IM     = 5'd24,
    CMD_ALT_RD = 5'd25,
    CMD_ALT_WR = 5'd26
  } cmd_t;

  localparam logic [3:0] SEL_A = 4'd0;
  localparam logic [3:0] SEL_F = 4'd1;
  localparam logic [3:0] SEL_I = 4'd8;
  localparam logic [3:0] SEL_R = 4'd9;

  localparam logic [2:0] PR_BC = 3'd0;
  localparam logic [2:0] PR_DE = 3'd1;
  localparam logic [2:0] PR_HL = 3'd2;
  localparam logic [2:0] PR_SP = 3'd3;
  localparam logic [2:0] PR_PC = 3'd4;
  localparam logic [2:0] PR_AF = 3'd5;
  localparam logic [2:0] PR_IX = 3'd6;
  localparam logic [2:0] PR_IY = 3'd7;

  localparam int FB_S  = 7;
  localparam int FB_Z  = 6;
  localparam int FB_H  = 4;
  localparam int FB_PV = 2;
  localparam int FB_N  = 1;
  localparam int FB_C  = 0;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [3:0]  reg8_sel;
    logic [2:0]  pair_sel;
    logic [15:0] data;
    logic        carry_in;
    logic [3:0]  cond_code;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [7:0]  flags_out;
    logic        cond_met;
  } out_item_t;

  function automatic logic [7:0] sz8(input logic [7:0] v);
    sz8 = {v[7], (v == 8'h00), 6'b0};
  endfunction

  function automatic logic [7:0] sz16(input logic [15:0] v);
    sz16 = {v[15], (v == 16'h0000), 6'b0};
  endfunction

  function automatic logic [7:0] par8(input logic [7:0] v);
    par8 = {5'b0, ~(^v), 2'b0};
  endfunction

  function automatic logic test_cond(input logic [3:0] cc, input logic [7:0] f);
    case (cc)
      4'd0: test_cond = ~f[FB_Z];
      4'd1: test_cond = f[FB_Z];
      4'd2: test_cond = ~f[FB_C];
      4'd3: test_cond = f[FB_C];
      4'd4: test_cond = ~f[FB_PV];
      4'd5: test_cond = f[FB_PV];
      4'd6: test_cond = ~f[FB_S];
      4'd7: test_cond = f[FB_S];
      4'd8: test_cond = 1'b1;
      default: test_cond = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cpu_register_file_flag_alu.sv =====
// cpu_register_file_flag_alu: 8-bit cpu register file with flag alu
// depends on crf_pkg
`default_nettype none
// One command per transfer. An accepted command lands in an input register;
// when the result register is free, a single pass of combinational logic
// (8/16-bit adders, parity, decimal correction) reads the register state,
// commits the update and loads the result register. A new command can
// enter every cycle, so the sustained rate is one command per cycle; the
// result register stalls the pipe only when its content has not been
// taken. Main and alternate banks, SP, IX and IY hold no reset value:
// read them only after a write. Flags are rebuilt with bits 5 and 3
// cleared.
module cpu_register_file_flag_alu (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire crf_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output crf_pkg::out_item_t        out_data
);
  import crf_pkg::*;

  // pipeline control
  logic      stg_valid;
  in_item_t  stg;
  logic      adv;
  out_item_t res_next;

  // architectural state
  logic [7:0]  main_regs [8];
  logic [7:0]  alt_regs [8];
  logic [7:0]  ireg, rreg;
  logic [15:0] sp, pc, ix, iy;
  logic        iff1, iff2;
  logic [1:0]  im;

  // next values
  logic [7:0]  main_next [8];
  logic [7:0]  alt_next [8];
  logic [7:0]  ireg_next, rreg_next;
  logic [15:0] sp_next, pc_next, ix_next, iy_next;
  logic        iff1_next, iff2_next;
  logic [1:0]  im_next;

  // stage advances when the result register is free or being drained
  assign adv      = ~out_valid | out_ready;
  assign in_ready = ~stg_valid | adv;

  // --- combinational helpers
  function automatic logic [7:0] rd8(input logic [3:0] s, input logic [7:0] m [8],
                                     input logic [7:0] iv, input logic [7:0] rv);
    if (s < 4'd8) rd8 = m[s[2:0]];
    else if (s == SEL_I) rd8 = iv;
    else if (s == SEL_R) rd8 = rv;
    else rd8 = 8'h00;
  endfunction

  logic [7:0]  fold, op8, r8, f8, daa_adj;
  logic [15:0] pa, pb, r16;
  logic [16:0] sum17;
  logic [8:0]  sum9;
  logic [4:0]  hsum;
  logic [2:0]  src;
  logic        c16, rc;
  logic [15:0] rv;

  always_comb begin
    fold = main_regs[1];
    op8  = rd8(stg.reg8_sel, main_regs, ireg, rreg);
    src  = stg.data[2:0];
    case (stg.pair_sel)
      PR_BC: pa = {main_regs[2], main_regs[3]};
      PR_DE: pa = {main_regs[4], main_regs[5]};
      PR_HL: pa = {main_regs[6], main_regs[7]};
      PR_SP: pa = sp;
      PR_PC: pa = pc;
      PR_AF: pa = {main_regs[0], main_regs[1]};
      PR_IX: pa = ix;
      default: pa = iy;
    endcase
    if (stg.cmd == CMD_SBCHL) pa = {main_regs[6], main_regs[7]};
    case (src)
      PR_BC: pb = {main_regs[2], main_regs[3]};
      PR_DE: pb = {main_regs[4], main_regs[5]};
      PR_HL: pb = {main_regs[6], main_regs[7]};
      PR_SP: pb = sp;
      PR_PC: pb = pc;
      PR_AF: pb = {main_regs[0], main_regs[1]};
      PR_IX: pb = ix;
      default: pb = iy;
    endcase

    main_next = main_regs;
    alt_next  = alt_regs;
    ireg_next = ireg;
    rreg_next = rreg;
    sp_next   = sp;
    pc_next   = pc;
    ix_next   = ix;
    iy_next   = iy;
    iff1_next = iff1;
    iff2_next = iff2;
    im_next   = im;
    rv        = 16'h0000;
    r8        = 8'h00;
    r16       = 16'h0000;
    f8        = fold;
    sum9      = 9'h000;
    sum17     = 17'h00000;
    hsum      = 5'h00;
    daa_adj   = 8'h00;
    c16       = 1'b0;
    rc        = 1'b0;

    case (stg.cmd)
      CMD_RD8: rv = {8'h00, op8};
      CMD_WR8, CMD_INC8, CMD_DEC8, CMD_ADD8, CMD_RLC, CMD_RRC, CMD_RL, CMD_RR: begin
        case (stg.cmd)
          CMD_WR8: r8 = stg.data[7:0];
          CMD_INC8: begin
            r8 = op8 + 8'd1;
            f8 = sz8(r8) | {3'b0, (op8[3:0] == 4'hF), 1'b0, (op8 == 8'h7F), 1'b0, fold[FB_C]};
          end
          CMD_DEC8: begin
            r8 = op8 - 8'd1;
            f8 = sz8(r8) | {3'b0, (op8[3:0] == 4'h0), 1'b0, (op8 == 8'h80), 1'b1, fold[FB_C]};
          end
          CMD_ADD8: begin
            sum9 = {1'b0, op8} + {1'b0, stg.data[7:0]} + {8'h00, stg.carry_in};
            hsum = {1'b0, op8[3:0]} + {1'b0, stg.data[3:0]} + {4'h0, stg.carry_in};
            r8   = sum9[7:0];
            if (stg.reg8_sel == SEL_A)
              f8 = sz8(r8) | {3'b0, hsum[4], 1'b0,
                   (~(op8[7] ^ stg.data[7]) & (op8[7] ^ r8[7])), 1'b0, sum9[8]};
          end
          default: begin
            case (stg.cmd)
              CMD_RLC: begin rc = op8[7]; r8 = {op8[6:0], op8[7]}; end
              CMD_RRC: begin rc = op8[0]; r8 = {op8[0], op8[7:1]}; end
              CMD_RL:  begin rc = op8[7]; r8 = {op8[6:0], fold[FB_C]}; end
              default: begin rc = op8[0]; r8 = {fold[FB_C], op8[7:1]}; end
            endcase
            if (stg.reg8_sel == SEL_A)
              f8 = (fold & 8'hC4) | {7'b0, rc};
            else
              f8 = sz8(r8) | par8(r8) | {7'b0, rc};
          end
        endcase
        if (stg.reg8_sel < 4'd8) main_next[stg.reg8_sel[2:0]] = r8;
        else if (stg.reg8_sel == SEL_I) ireg_next = r8;
        else if (stg.reg8_sel == SEL_R) rreg_next = r8;
        rv = (stg.reg8_sel <= SEL_R) ? {8'h00, r8} : 16'h0000;
        if (stg.cmd != CMD_WR8) rv = {8'h00, r8};
        // rebuilt flags win over a result stored in F; plain writes and
        // add8 to anything but A leave the stored value alone
        if (stg.cmd != CMD_WR8 && !(stg.cmd == CMD_ADD8 && stg.reg8_sel != SEL_A))
          main_next[1] = f8;
      end
      CMD_RD16: rv = pa;
      CMD_WR16, CMD_INC16, CMD_DEC16, CMD_ADD16, CMD_SBCHL: begin
        case (stg.cmd)
          CMD_WR16:  r16 = stg.data;
          CMD_INC16: r16 = pa + 16'd1;
          CMD_DEC16: r16 = pa - 16'd1;
          CMD_ADD16: begin
            sum17 = {1'b0, pa} + {1'b0, pb} + {16'h0000, stg.carry_in & fold[FB_C]};
            r16   = sum17[15:0];
            c16   = sum17[16];
          end
          default: begin
            sum17 = {1'b0, pa} - {1'b0, pb} - {16'h0000, fold[FB_C]};
            r16   = sum17[15:0];
            c16   = sum17[16];
          end
        endcase
        case (stg.cmd == CMD_SBCHL ? PR_HL : stg.pair_sel)
          PR_BC: begin main_next[2] = r16[15:8]; main_next[3] = r16[7:0]; end
          PR_DE: begin main_next[4] = r16[15:8]; main_next[5] = r16[7:0]; end
          PR_HL: begin main_next[6] = r16[15:8]; main_next[7] = r16[7:0]; end
          PR_SP: sp_next = r16;
          PR_PC: pc_next = r16;
          PR_AF: begin main_next[0] = r16[15:8]; main_next[1] = r16[7:0]; end
          PR_IX: ix_next = r16;
          default: iy_next = r16;
        endcase
        rv = r16;
        if (stg.cmd == CMD_ADD16) begin
          if (stg.pair_sel == PR_HL && stg.carry_in)
            main_next[1] = sz16(r16) | {5'b0,
              (~(pa[15] ^ pb[15]) & (pa[15] ^ r16[15])), 1'b0, c16};
          else if (stg.pair_sel == PR_HL || stg.pair_sel == PR_IX || stg.pair_sel == PR_IY)
            main_next[1] = (fold & 8'hC4) | {7'b0, c16};
        end else if (stg.cmd == CMD_SBCHL) begin
          main_next[1] = sz16(r16) | {5'b0,
            ((pa[15] ^ pb[15]) & (pa[15] ^ r16[15])), 1'b1, c16};
        end
      end
      CMD_DAA: begin
        op8 = main_regs[0];
        if (fold[FB_H] || op8[3:0] > 4'd9) daa_adj[3:0] = 4'h6;
        rc = fold[FB_C] || (op8 > 8'h99);
        if (rc) daa_adj[7:4] = 4'h6;
        r8 = fold[FB_N] ? (op8 - daa_adj) : (op8 + daa_adj);
        main_next[0] = r8;
        main_next[1] = sz8(r8) | par8(r8) | {3'b0,
          (fold[FB_N] ? (fold[FB_H] && op8[3:0] < 4'd6) : (op8[3:0] > 4'd9)),
          2'b0, fold[FB_N], rc};
        rv = {8'h00, r8};
      end
      CMD_NEG: begin
        op8 = main_regs[0];
        r8  = 8'h00 - op8;
        main_next[0] = r8;
        main_next[1] = sz8(r8) | {3'b0, (op8[3:0] != 4'h0), 1'b0,
          (op8 == 8'h80), 1'b1, (op8 != 8'h00)};
        rv = {8'h00, r8};
      end
      CMD_EXAF: begin
        for (int k = 0; k < 2; k++) begin
          main_next[k] = alt_regs[k];
          alt_next[k]  = main_regs[k];
        end
      end
      CMD_EXX: begin
        for (int k = 2; k < 8; k++) begin
          main_next[k] = alt_regs[k];
          alt_next[k]  = main_regs[k];
        end
      end
      CMD_JR: begin
        r16 = pc + {{8{stg.data[7]}}, stg.data[7:0]};
        pc_next = r16;
        rv = r16;
      end
      CMD_RESET: begin
        iff1_next = 1'b0;
        iff2_next = 1'b0;
        pc_next   = 16'h0000;
        ireg_next = 8'h00;
        rreg_next = 8'h00;
        im_next   = 2'd0;
      end
      CMD_IFF1: iff1_next = stg.data[0];
      CMD_IFF2: iff2_next = stg.data[0];
      CMD_IM:   im_next = stg.data[1:0];
      CMD_ALT_RD: rv = stg.reg8_sel[3] ? 16'h0000 : {8'h00, alt_regs[stg.reg8_sel[2:0]]};
      CMD_ALT_WR: if (!stg.reg8_sel[3]) begin
        alt_next[stg.reg8_sel[2:0]] = stg.data[7:0];
        rv = {8'h00, stg.data[7:0]};
      end
      default: ;
    endcase

    res_next.read_value = rv;
    res_next.flags_out  = main_next[1];
    res_next.cond_met   = test_cond(stg.cond_code, main_next[1]);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
    if (in_ready && in_valid) stg <= in_data;
  end

  // state commit and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ireg      <= 8'h00;
      rreg      <= 8'h00;
      pc        <= 16'h0000;
      iff1      <= 1'b0;
      iff2      <= 1'b0;
      im        <= 2'd0;
    end else begin
      if (adv) out_valid <= stg_valid;
      if (adv && stg_valid) begin
        ireg <= ireg_next;
        rreg <= rreg_next;
        pc   <= pc_next;
        iff1 <= iff1_next;
        iff2 <= iff2_next;
        im   <= im_next;
      end
    end
    if (adv && stg_valid) begin
      main_regs <= main_next;
      alt_regs  <= alt_next;
      sp        <= sp_next;
      ix        <= ix_next;
      iy        <= iy_next;
      out_data  <= res_next;
    end
  end

`ifndef ASSERT_OFF
  // a held result stays unchanged until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");
  // a staged command always reaches the result register next cycle when free
  a_flow: assert property (@(posedge clk) disable iff (rst)
    stg_valid && adv |=> out_valid)
    else $error("staged command lost");
  // cpu reset clears the program counter and both interrupt enables
  a_rst: assert property (@(posedge clk) disable iff (rst)
    stg_valid && adv && stg.cmd == CMD_RESET |=> pc == 16'h0000 && !iff1 && !iff2)
    else $error("cpu reset incomplete");
`endif

endmodule
`default_nettype wire

// ===== tb/cpu_register_file_flag_alu_test.sv =====
// cpu_register_file_flag_alu_test: self-checking bench for the register file and flag alu
// depends on crf_pkg and cpu_register_file_flag_alu
`default_nettype none
module cpu_register_file_flag_alu_test;
  timeunit 1ns;
  timeprecision 1ps;
  import crf_pkg::*;

  localparam int RANDOM_OPS = 1350;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  cpu_register_file_flag_alu uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the cpu state
  logic [7:0]  main_bank [8];
  logic [7:0]  alt_bank [8];
  logic [7:0]  vec_i, refresh_r;
  logic [15:0] sp_q, pc_q, ix_q, iy_q;
  logic        ie1, ie2;
  logic [1:0]  imode;

  out_item_t result_q [$];
  int  fail_count = 0;
  int  mismatch_count = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;

  // directed rows; want is only used when spelled out
  typedef struct {
    in_item_t  stim;
    bit        fixed;
    out_item_t want;
  } row_t;
  row_t rows [$];

  function automatic logic [7:0] get8(logic [3:0] sel);
    if (sel < 4'd8) return main_bank[sel[2:0]];
    if (sel == SEL_I) return vec_i;
    if (sel == SEL_R) return refresh_r;
    return 8'h00;
  endfunction

  function automatic void put8(logic [3:0] sel, logic [7:0] v);
    if (sel < 4'd8) main_bank[sel[2:0]] = v;
    else if (sel == SEL_I) vec_i = v;
    else if (sel == SEL_R) refresh_r = v;
  endfunction

  function automatic logic [15:0] get16(logic [2:0] p);
    case (p)
      PR_BC: return {main_bank[2], main_bank[3]};
      PR_DE: return {main_bank[4], main_bank[5]};
      PR_HL: return {main_bank[6], main_bank[7]};
      PR_SP: return sp_q;
      PR_PC: return pc_q;
      PR_AF: return {main_bank[0], main_bank[1]};
      PR_IX: return ix_q;
      default: return iy_q;
    endcase
  endfunction

  function automatic void put16(logic [2:0] p, logic [15:0] v);
    case (p)
      PR_BC: {main_bank[2], main_bank[3]} = v;
      PR_DE: {main_bank[4], main_bank[5]} = v;
      PR_HL: {main_bank[6], main_bank[7]} = v;
      PR_SP: sp_q = v;
      PR_PC: pc_q = v;
      PR_AF: {main_bank[0], main_bank[1]} = v;
      PR_IX: ix_q = v;
      default: iy_q = v;
    endcase
  endfunction

  // sign and zero flags, parity flag set on even parity
  function automatic logic [7:0] sign_zero8(logic [7:0] v);
    return {v[7], v == 8'h00, 6'b0};
  endfunction

  function automatic logic [7:0] sign_zero16(logic [15:0] v);
    return {v[15], v == 16'h0000, 6'b0};
  endfunction

  function automatic logic [7:0] even_pv(logic [7:0] v);
    return (^v) ? 8'h00 : 8'h04;
  endfunction

  function automatic logic flag_test(logic [3:0] cc, logic [7:0] f);
    case (cc)
      4'd0: return !f[FB_Z];
      4'd1: return f[FB_Z];
      4'd2: return !f[FB_C];
      4'd3: return f[FB_C];
      4'd4: return !f[FB_PV];
      4'd5: return f[FB_PV];
      4'd6: return !f[FB_S];
      4'd7: return f[FB_S];
      4'd8: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // runs one command on the shadow state and returns what the block should answer
  function automatic out_item_t execute_cmd(in_item_t it);
    logic [7:0]  fold, f, a8, b8, r8;
    logic [16:0] s;
    logic [15:0] a16, b16, rv;
    logic        c1;
    logic [4:0]  nib;
    out_item_t   o;
    fold = main_bank[1];
    rv = 16'h0000;
    case (it.cmd)
      CMD_RD8: rv = {8'h00, get8(it.reg8_sel)};
      CMD_WR8: begin
        put8(it.reg8_sel, it.data[7:0]);
        rv = {8'h00, get8(it.reg8_sel)};
      end
      CMD_RD16: rv = get16(it.pair_sel);
      CMD_WR16: begin
        put16(it.pair_sel, it.data);
        rv = it.data;
      end
      CMD_INC8: begin
        a8 = get8(it.reg8_sel);
        r8 = a8 + 8'd1;
        put8(it.reg8_sel, r8);
        rv = {8'h00, r8};
        main_bank[1] = (fold & 8'h01) | sign_zero8(r8) | ((a8[3:0] == 4'hF) ? 8'h10 : 8'h00)
                       | ((a8 == 8'h7F) ? 8'h04 : 8'h00);
      end
      CMD_DEC8: begin
        a8 = get8(it.reg8_sel);
        r8 = a8 - 8'd1;
        put8(it.reg8_sel, r8);
        rv = {8'h00, r8};
        main_bank[1] = (fold & 8'h01) | sign_zero8(r8) | 8'h02
                       | ((a8[3:0] == 4'h0) ? 8'h10 : 8'h00) | ((a8 == 8'h80) ? 8'h04 : 8'h00);
      end
      CMD_INC16: begin
        rv = get16(it.pair_sel) + 16'd1;
        put16(it.pair_sel, rv);
      end
      CMD_DEC16: begin
        rv = get16(it.pair_sel) - 16'd1;
        put16(it.pair_sel, rv);
      end
      CMD_ADD8: begin
        a8 = get8(it.reg8_sel);
        b8 = it.data[7:0];
        s = {9'b0, a8} + {9'b0, b8} + {16'b0, it.carry_in};
        put8(it.reg8_sel, s[7:0]);
        rv = {8'h00, s[7:0]};
        // flags move only when the destination is the accumulator
        if (it.reg8_sel == SEL_A) begin
          nib = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'b0, it.carry_in};
          f = sign_zero8(s[7:0]) | (nib[4] ? 8'h10 : 8'h00) | {7'b0, s[8]};
          if ((~(a8 ^ b8) & (a8 ^ s[7:0])) & 8'h80) f |= 8'h04;
          main_bank[1] = f;
        end
      end
      CMD_ADD16: begin
        a16 = get16(it.pair_sel);
        b16 = get16(it.data[2:0]);
        c1 = it.carry_in & fold[0];
        s = {1'b0, a16} + {1'b0, b16} + {16'b0, c1};
        put16(it.pair_sel, s[15:0]);
        rv = s[15:0];
        f = {7'b0, s[16]};
        if (it.pair_sel == PR_HL && it.carry_in) begin
          f |= sign_zero16(s[15:0]);
          if ((~(a16 ^ b16) & (a16 ^ s[15:0])) & 16'h8000) f |= 8'h04;
          main_bank[1] = f;
        end else if (it.pair_sel == PR_HL || it.pair_sel == PR_IX || it.pair_sel == PR_IY) begin
          main_bank[1] = f | (fold & 8'hC4);
        end
      end
      CMD_SBCHL: begin
        a16 = get16(PR_HL);
        b16 = get16(it.data[2:0]);
        c1 = fold[0];
        s = {1'b0, a16} - {1'b0, b16} - {16'b0, c1};
        put16(PR_HL, s[15:0]);
        rv = s[15:0];
        f = sign_zero16(s[15:0]) | 8'h02;
        if (({1'b0, b16} + {16'b0, c1}) > {1'b0, a16}) f |= 8'h01;
        if (((a16 ^ b16) & (a16 ^ s[15:0])) & 16'h8000) f |= 8'h04;
        main_bank[1] = f;
      end
      CMD_RLC, CMD_RRC, CMD_RL, CMD_RR: begin
        a8 = get8(it.reg8_sel);
        case (it.cmd)
          CMD_RLC: begin c1 = a8[7]; r8 = {a8[6:0], a8[7]}; end
          CMD_RRC: begin c1 = a8[0]; r8 = {a8[0], a8[7:1]}; end
          CMD_RL:  begin c1 = a8[7]; r8 = {a8[6:0], fold[0]}; end
          default: begin c1 = a8[0]; r8 = {fold[0], a8[7:1]}; end
        endcase
        put8(it.reg8_sel, r8);
        rv = {8'h00, r8};
        // accumulator rotates keep s z p/v
        if (it.reg8_sel == SEL_A) f = fold & 8'hC4;
        else f = sign_zero8(r8) | even_pv(r8);
        main_bank[1] = f | {7'b0, c1};
      end
      CMD_DAA: begin
        a8 = main_bank[0];
        b8 = 8'h00;
        c1 = 1'b0;
        if (fold[4] || a8[3:0] > 4'd9) b8 |= 8'h06;
        if (fold[0] || a8 > 8'h99) begin
          b8 |= 8'h60;
          c1 = 1'b1;
        end
        r8 = fold[1] ? a8 - b8 : a8 + b8;
        if (fold[1]) f = (fold[4] && a8[3:0] < 4'd6) ? 8'h10 : 8'h00;
        else f = (a8[3:0] > 4'd9) ? 8'h10 : 8'h00;
        main_bank[0] = r8;
        rv = {8'h00, r8};
        main_bank[1] = sign_zero8(r8) | even_pv(r8) | f | (fold & 8'h02) | {7'b0, c1};
      end
      CMD_NEG: begin
        a8 = main_bank[0];
        r8 = 8'h00 - a8;
        main_bank[0] = r8;
        rv = {8'h00, r8};
        main_bank[1] = sign_zero8(r8) | 8'h02 | ((a8[3:0] != 4'h0) ? 8'h10 : 8'h00)
                       | ((a8 == 8'h80) ? 8'h04 : 8'h00) | ((a8 != 8'h00) ? 8'h01 : 8'h00);
      end
      CMD_EXAF: begin
        for (int k = 0; k < 2; k++) begin
          r8 = main_bank[k];
          main_bank[k] = alt_bank[k];
          alt_bank[k] = r8;
        end
      end
      CMD_EXX: begin
        for (int k = 2; k < 8; k++) begin
          r8 = main_bank[k];
          main_bank[k] = alt_bank[k];
          alt_bank[k] = r8;
        end
      end
      CMD_JR: begin
        pc_q = pc_q + {{8{it.data[7]}}, it.data[7:0]};
        rv = pc_q;
      end
      CMD_RESET: begin
        ie1 = 1'b0;
        ie2 = 1'b0;
        pc_q = 16'h0000;
        vec_i = 8'h00;
        refresh_r = 8'h00;
        imode = 2'd0;
      end
      CMD_IFF1: ie1 = it.data[0];
      CMD_IFF2: ie2 = it.data[0];
      CMD_IM:   imode = it.data[1:0];
      CMD_ALT_RD: rv = (it.reg8_sel < 4'd8) ? {8'h00, alt_bank[it.reg8_sel[2:0]]} : 16'h0000;
      CMD_ALT_WR: begin
        if (it.reg8_sel < 4'd8) begin
          alt_bank[it.reg8_sel[2:0]] = it.data[7:0];
          rv = {8'h00, it.data[7:0]};
        end
      end
      default: ;
    endcase
    o.read_value = rv;
    o.flags_out = main_bank[1];
    o.cond_met = flag_test(it.cond_code, main_bank[1]);
    return o;
  endfunction

  task automatic add_row(cmd_t c, logic [3:0] sel, logic [2:0] p, logic [15:0] d,
                         logic ci, logic [3:0] cc, bit fixed = 1'b0,
                         logic [15:0] rv = '0, logic [7:0] fl = '0, logic cm = 1'b0);
    row_t r;
    r.stim = '{cmd: c, reg8_sel: sel, pair_sel: p, data: d, carry_in: ci, cond_code: cc};
    r.fixed = fixed;
    r.want = '{read_value: rv, flags_out: fl, cond_met: cm};
    rows.push_back(r);
  endtask

  function automatic in_item_t random_cmd();
    in_item_t it;
    logic [15:0] corner [6] = '{16'h0000, 16'hFFFF, 16'h007F, 16'h0080, 16'h8000, 16'h00FF};
    it.cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(27, 31))
                                          : 5'($urandom_range(0, 26));
    it.reg8_sel = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
    it.pair_sel = 3'($urandom_range(0, 7));
    it.data = ($urandom_range(0, 7) == 0) ? corner[$urandom_range(0, 5)] : 16'($urandom);
    it.carry_in = 1'($urandom);
    it.cond_code = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
    return it;
  endfunction

  // one command transfer; the gap before it is drawn per command
  task automatic send_cmd(in_item_t it, bit fixed, out_item_t want);
    int gap;
    out_item_t got;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    got = execute_cmd(it);
    result_q.push_back(fixed ? want : got);
  endtask

  // result side: random stall per result, one long hold-off on request
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = gaps_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // checker: every result transfer against the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        fail_count++;
        $display("unexpected result %h", out_data);
      end else begin
        exp_r = result_q.pop_front();
        if (out_data.read_value !== exp_r.read_value || out_data.flags_out !== exp_r.flags_out
            || out_data.cond_met !== exp_r.cond_met) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: value %h/%h flags %h/%h cond %b/%b (expected/actual)",
                     exp_r.read_value, out_data.read_value, exp_r.flags_out,
                     out_data.flags_out, exp_r.cond_met, out_data.cond_met);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    out_item_t none;
    none = '0;
    vec_i = 8'h00;
    refresh_r = 8'h00;
    pc_q = 16'h0000;
    ie1 = 1'b0;
    ie2 = 1'b0;
    imode = 2'd0;
    for (int k = 0; k < 8; k++) begin
      main_bank[k] = 8'h00;
      alt_bank[k] = 8'h00;
    end

    // flags first: every result carries F, so it must be defined before anything else
    add_row(CMD_WR16, SEL_A, PR_AF, 16'h00FF, 1'b0, 4'd8, 1'b1, 16'h00FF, 8'hFF, 1'b1);
    for (int k = 0; k < 8; k++)
      add_row(CMD_ALT_WR, 4'(k), PR_BC, 16'($urandom), 1'b0, 4'd8);
    // reset values of I, R and PC; bad condition codes never hold
    add_row(CMD_RD8, SEL_I, PR_BC, 16'h0000, 1'b0, 4'd1, 1'b1, 16'h0000, 8'hFF, 1'b1);
    add_row(CMD_RD8, SEL_R, PR_BC, 16'h0000, 1'b0, 4'd9, 1'b1, 16'h0000, 8'hFF, 1'b0);
    add_row(CMD_RD16, SEL_A, PR_PC, 16'h0000, 1'b0, 4'd15, 1'b1, 16'h0000, 8'hFF, 1'b0);
    add_row(CMD_WR16, SEL_A, PR_BC, 16'hFFFF, 1'b0, 4'd3, 1'b1, 16'hFFFF, 8'hFF, 1'b1);
    add_row(CMD_WR16, SEL_A, PR_DE, 16'h0000, 1'b0, 4'd0, 1'b1, 16'h0000, 8'hFF, 1'b0);
    add_row(CMD_WR16, SEL_A, PR_HL, 16'h8000, 1'b0, 4'd7, 1'b1, 16'h8000, 8'hFF, 1'b1);
    add_row(CMD_WR16, SEL_A, PR_SP, 16'h1234, 1'b0, 4'd8);
    add_row(CMD_WR16, SEL_A, PR_IX, 16'hFFFF, 1'b0, 4'd8);
    add_row(CMD_WR16, SEL_A, PR_IY, 16'h0001, 1'b0, 4'd8);
    // 00 + ff + carry wraps to zero with half carry and carry
    add_row(CMD_ADD8, SEL_A, PR_BC, 16'h00FF, 1'b1, 4'd3, 1'b1, 16'h0000, 8'h51, 1'b1);
    // bad selector: phantom zero register still moves the flags
    add_row(CMD_INC8, 4'd15, PR_BC, 16'h0000, 1'b0, 4'd2, 1'b1, 16'h0001, 8'h01, 1'b0);
    add_row(CMD_RD8, 4'd12, PR_BC, 16'h0000, 1'b0, 4'd8, 1'b1, 16'h0000, 8'h01, 1'b1);
    add_row(CMD_DEC8, 4'd2, PR_BC, 16'h0000, 1'b0, 4'd6);
    add_row(CMD_INC8, SEL_F, PR_BC, 16'h0000, 1'b0, 4'd4);
    add_row(CMD_INC16, SEL_A, PR_IX, 16'h0000, 1'b0, 4'd1);
    add_row(CMD_DEC16, SEL_A, PR_PC, 16'h0000, 1'b0, 4'd5);
    add_row(CMD_ADD16, SEL_A, PR_HL, {13'b0, PR_HL}, 1'b1, 4'd5);
    add_row(CMD_ADD16, SEL_A, PR_IY, {13'b0, PR_BC}, 1'b0, 4'd3);
    add_row(CMD_SBCHL, SEL_A, PR_BC, {13'b0, PR_SP}, 1'b0, 4'd2);
    add_row(CMD_RLC, 4'd3, PR_BC, 16'h0000, 1'b0, 4'd3);
    add_row(CMD_RRC, SEL_A, PR_BC, 16'h0000, 1'b0, 4'd4);
    add_row(CMD_RL, 4'd7, PR_BC, 16'h0000, 1'b0, 4'd6);
    add_row(CMD_RR, SEL_F, PR_BC, 16'h0000, 1'b0, 4'd7);
    add_row(CMD_WR8, SEL_A, PR_BC, 16'h009A, 1'b0, 4'd8);
    add_row(CMD_DAA, SEL_A, PR_BC, 16'h0000, 1'b0, 4'd3);
    add_row(CMD_NEG, SEL_A, PR_BC, 16'h0000, 1'b0, 4'd5);
    add_row(CMD_EXAF, SEL_A, PR_BC, 16'h0000, 1'b0, 4'd8);
    add_row(CMD_EXX, SEL_A, PR_BC, 16'h0000, 1'b0, 4'd8);
    add_row(CMD_JR, SEL_A, PR_BC, 16'h0080, 1'b0, 4'd8);
    add_row(CMD_IFF1, SEL_A, PR_BC, 16'hFFFF, 1'b0, 4'd8);
    add_row(CMD_IFF2, SEL_A, PR_BC, 16'h0001, 1'b0, 4'd8);
    add_row(CMD_IM, SEL_A, PR_BC, 16'h0003, 1'b0, 4'd8);
    add_row(CMD_COND, SEL_A, PR_BC, 16'h0000, 1'b0, 4'd0);
    add_row(CMD_ALT_RD, 4'd8, PR_BC, 16'h0000, 1'b0, 4'd8);
    add_row(CMD_RESET, SEL_A, PR_BC, 16'h0000, 1'b0, 4'd8);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) send_cmd(rows[k].stim, rows[k].fixed, rows[k].want);

    // random commands; back-to-back stretches and one long result hold-off
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 200 == 100) gaps_on = 1'b0;
      if (n % 200 == 0) gaps_on = 1'b1;
      if (n == 600) hold_req = 1'b1;
      send_cmd(random_cmd(), 1'b0, none);
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/crf_pkg.sv
hdl/cpu_register_file_flag_alu.sv
tb/cpu_register_file_flag_alu_test.sv
